>>> src/assert_macros.svh
// Assertion macros used by the RTL files that include this header.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: property does not hold");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: expected follow-up missing");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/sevlog_pkg.sv
// ---------------------------------------------------------------------------
// sevlog_pkg
// Types and codes shared by the error log modules.
// ---------------------------------------------------------------------------
package sevlog_pkg;

  typedef enum logic [2:0] {
    MODE_REPORT  = 3'd0,
    MODE_ACK     = 3'd1,
    MODE_CLEAR   = 3'd2,
    MODE_PROCESS = 3'd3,
    MODE_PANEL   = 3'd4,
    MODE_READ    = 3'd5,
    MODE_CHECK   = 3'd6,
    MODE_NONE    = 3'd7
  } mode_t;

  localparam logic [1:0] LVL_WARN = 2'd0;
  localparam logic [1:0] LVL_ERR  = 2'd1;
  localparam logic [1:0] LVL_CRIT = 2'd2;
  localparam logic [1:0] LVL_MAX  = 2'd3;

  localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

  typedef struct packed {
    logic [1:0]  level;
    logic [15:0] source;
    logic [15:0] message;
    logic [31:0] stamp;
    logic        acked;
  } entry_t;

  typedef struct packed {
    logic ahead;   // entry a ranks ahead of entry b
    logic stale;   // entry a is a warning older than the timeout
  } cmp_res_t;

endpackage

>>> src/sevlog_mem.sv
// ---------------------------------------------------------------------------
// sevlog_mem
// Entry storage: one write port, one registered read port.
// ---------------------------------------------------------------------------
module sevlog_mem #(
  parameter int Depth = 9,
  parameter int Aw    = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [Aw-1:0]       waddr,
  input  sevlog_pkg::entry_t  wdata,
  input  logic [Aw-1:0]       raddr,
  output sevlog_pkg::entry_t  rdata
);
  import sevlog_pkg::*;

  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/sevlog_cmp.sv
// ---------------------------------------------------------------------------
// sevlog_cmp
// Shared compare unit: rank order and warning age test.
// ---------------------------------------------------------------------------
module sevlog_cmp (
  input  sevlog_pkg::entry_t    a,
  input  sevlog_pkg::entry_t    b,
  input  logic [31:0]           now,
  input  logic [31:0]           timeout,
  output sevlog_pkg::cmp_res_t  res
);
  import sevlog_pkg::*;

  logic [31:0] age;

  always_comb begin
    age = now - a.stamp;  // wraps modulo 2^32
    res.stale = (a.level == LVL_WARN) && (age > timeout);
    if (a.level != b.level) begin
      res.ahead = a.level > b.level;
    end else begin
      res.ahead = a.stamp > b.stamp;
    end
  end

endmodule

>>> src/severity_ranked_error_log.sv
// ---------------------------------------------------------------------------
// severity_ranked_error_log
// Bounded error log ranked by severity, one status beat per operation.
// ---------------------------------------------------------------------------
// One operation is in flight at a time; in_stall is high until its status
// beat is loaded into the output register. Every operation ends with a status
// sweep of the N entries held through the single read port of the entry
// memory, then loads the beat once the output register is not held by
// out_stall. Report, process and check first run a compaction sweep.
// Acknowledge and read look the entry up; acknowledge of a non-critical entry
// then runs the same compaction sweep. A report that overflows the log runs a
// stable bubble sort of LOG_DEPTH+1 entries, then drops the last.
module severity_ranked_error_log #(
  parameter int LOG_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [1:0]  level,
  input  logic [15:0] source_id,
  input  logic [15:0] message_id,
  input  logic [7:0]  entry_index,
  input  logic        panel_value,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  entry_count,
  output logic        has_pending,
  output logic        has_critical,
  output logic [1:0]  highest_level,
  output logic        panel_active,
  output logic        read_valid,
  output logic [1:0]  read_level,
  output logic [15:0] read_source,
  output logic [15:0] read_message,
  output logic [31:0] read_time,
  output logic        read_acked,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import sevlog_pkg::*;

  `include "assert_macros.svh"

  localparam int Slots = LOG_DEPTH + 1;
  localparam int Aw    = $clog2(Slots);
  localparam int Cw    = $clog2(LOG_DEPTH + 2);
  localparam logic [Cw-1:0] DepthC = Cw'(LOG_DEPTH);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_SCAN_RD = 14'b00000000000010,
    S_SCAN_EV = 14'b00000000000100,
    S_APPEND  = 14'b00000000001000,
    S_SORT_RD = 14'b00000000010000,
    S_SORT_EV = 14'b00000000100000,
    S_SORT_END= 14'b00000001000000,
    S_ACK_RD  = 14'b00000010000000,
    S_ACK_EV  = 14'b00000100000000,
    S_READ_RD = 14'b00001000000000,
    S_READ_EV = 14'b00010000000000,
    S_STAT_RD = 14'b00100000000000,
    S_STAT_EV = 14'b01000000000000,
    S_FINISH  = 14'b10000000000000
  } state_t;

  state_t         state;
  logic [Cw-1:0]  count;
  logic [Cw-1:0]  rptr;
  logic [Cw-1:0]  wptr;
  logic [Cw-1:0]  lim;
  logic           scan_ack;
  entry_t         carry;
  logic           crit;
  logic [1:0]     high;
  logic           panel_flag;
  logic [31:0]    timeout;

  mode_t          op_mode;
  logic [1:0]     op_level;
  logic [15:0]    op_source;
  logic [15:0]    op_message;
  logic [7:0]     op_index;
  logic [31:0]    op_now;

  logic           rd_valid;
  entry_t         rd_entry;

  logic           mem_we;
  logic [Aw-1:0]  mem_waddr;
  entry_t         mem_wdata;
  logic [Aw-1:0]  mem_raddr;
  entry_t         mem_rdata;
  cmp_res_t       cmp;
  logic           keep;
  logic           idx_hit;
  logic           load_out;
  entry_t         new_entry;

  sevlog_mem #(
    .Depth (Slots),
    .Aw    (Aw)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sevlog_cmp u_cmp (
    .a       (mem_rdata),
    .b       (carry),
    .now     (op_now),
    .timeout (timeout),
    .res     (cmp)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign idx_hit   = op_index < 8'(count);
  assign keep      = scan_ack ? (8'(rptr) != op_index) : !cmp.stale;
  assign load_out  = (state == S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    new_entry.level   = op_level;
    new_entry.source  = op_source;
    new_entry.message = op_message;
    new_entry.stamp   = op_now;
    new_entry.acked   = 1'b0;
  end

  // Memory port steering
  always_comb begin
    mem_raddr = rptr[Aw-1:0];
    mem_we    = 1'b0;
    mem_waddr = wptr[Aw-1:0];
    mem_wdata = mem_rdata;
    unique case (state)
      S_SCAN_EV: begin
        mem_we = keep;
      end
      S_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = count[Aw-1:0];
        mem_wdata = new_entry;
      end
      S_SORT_EV: begin
        mem_we    = (rptr != '0);
        mem_waddr = Aw'(rptr - 1'b1);
        mem_wdata = cmp.ahead ? mem_rdata : carry;
      end
      S_SORT_END: begin
        mem_we    = 1'b1;
        mem_waddr = lim[Aw-1:0];
        mem_wdata = carry;
      end
      S_ACK_RD, S_READ_RD: begin
        mem_raddr = op_index[Aw-1:0];
      end
      S_ACK_EV: begin
        mem_we          = (mem_rdata.level == LVL_CRIT);
        mem_waddr       = op_index[Aw-1:0];
        mem_wdata.acked = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      panel_flag <= 1'b0;
      timeout    <= TIMEOUT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_mode    <= mode_t'(mode);
            op_level   <= (level == LVL_MAX) ? LVL_CRIT : level;
            op_source  <= source_id;
            op_message <= message_id;
            op_index   <= entry_index;
            op_now     <= now_ms;
            crit       <= 1'b0;
            high       <= LVL_WARN;
            rd_valid   <= 1'b0;
            rd_entry   <= '0;
            rptr       <= '0;
            wptr       <= '0;
            scan_ack   <= 1'b0;
            unique case (mode_t'(mode))
              MODE_REPORT, MODE_PROCESS, MODE_CHECK: state <= S_SCAN_RD;
              MODE_ACK:   state <= S_ACK_RD;
              MODE_READ:  state <= S_READ_RD;
              MODE_CLEAR: begin
                count      <= '0;
                panel_flag <= 1'b0;
                state      <= S_STAT_RD;
              end
              MODE_PANEL: begin
                panel_flag <= panel_value;
                state      <= S_STAT_RD;
              end
              MODE_NONE:  state <= S_STAT_RD;
            endcase
          end
        end
        S_SCAN_RD: begin
          if (rptr == count) begin
            count <= wptr;
            rptr  <= '0;
            if (!scan_ack && op_mode == MODE_REPORT) begin
              state <= S_APPEND;
            end else begin
              if (!scan_ack && op_mode == MODE_PROCESS && wptr == '0) begin
                panel_flag <= 1'b0;
              end
              state <= S_STAT_RD;
            end
          end else begin
            state <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          if (keep) begin
            wptr <= wptr + 1'b1;
          end
          rptr  <= rptr + 1'b1;
          state <= S_SCAN_RD;
        end
        S_APPEND: begin
          count <= count + 1'b1;
          rptr  <= '0;
          if (count == DepthC) begin
            lim   <= DepthC;
            state <= S_SORT_RD;
          end else begin
            state <= S_STAT_RD;
          end
        end
        S_SORT_RD: begin
          state <= S_SORT_EV;
        end
        S_SORT_EV: begin
          // carry moves on only past entries that strictly rank ahead
          if (rptr == '0 || !cmp.ahead) begin
            carry <= mem_rdata;
          end
          if (rptr == lim) begin
            state <= S_SORT_END;
          end else begin
            rptr  <= rptr + 1'b1;
            state <= S_SORT_RD;
          end
        end
        S_SORT_END: begin
          rptr <= '0;
          if (lim == Cw'(1)) begin
            count <= DepthC;  // drop the lowest ranked entry
            state <= S_STAT_RD;
          end else begin
            lim   <= lim - 1'b1;
            state <= S_SORT_RD;
          end
        end
        S_ACK_RD: begin
          state <= idx_hit ? S_ACK_EV : S_STAT_RD;
        end
        S_ACK_EV: begin
          if (mem_rdata.level == LVL_CRIT) begin
            state <= S_STAT_RD;
          end else begin
            scan_ack <= 1'b1;
            state    <= S_SCAN_RD;
          end
        end
        S_READ_RD: begin
          state <= idx_hit ? S_READ_EV : S_STAT_RD;
        end
        S_READ_EV: begin
          rd_valid <= 1'b1;
          rd_entry <= mem_rdata;
          state    <= S_STAT_RD;
        end
        S_STAT_RD: begin
          state <= (rptr == count) ? S_FINISH : S_STAT_EV;
        end
        S_STAT_EV: begin
          if (!mem_rdata.acked) begin
            if (mem_rdata.level == LVL_CRIT) begin
              crit <= 1'b1;
            end
            if (mem_rdata.level > high) begin
              high <= mem_rdata.level;
            end
          end
          rptr  <= rptr + 1'b1;
          state <= S_STAT_RD;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (load_out) begin
            entry_count   <= 8'(count);
            has_pending   <= (count != '0);
            has_critical  <= crit;
            highest_level <= high;
            panel_active  <= panel_flag;
            read_valid    <= rd_valid;
            read_level    <= rd_entry.level;
            read_source   <= rd_entry.source;
            read_message  <= rd_entry.message;
            read_time     <= rd_entry.stamp;
            read_acked    <= rd_entry.acked;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, (state == S_IDLE) -> (count <= DepthC))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, state != S_IDLE)
  `ASSERT_ALWAYS(a_scan_order, clk, rst, (state == S_SCAN_EV) -> (wptr <= rptr))
  `ASSERT_ALWAYS(a_empty_status, clk, rst, (out_valid && entry_count == 8'd0) -> (!has_pending && !has_critical))

endmodule
